>>> rtl/core/lcd_rect_fill_command_gen_defines.svh
// Assertion macros shared by the rectangle fill command generator RTL
`ifndef LCD_RECT_FILL_COMMAND_GEN_DEFINES_SVH
`define LCD_RECT_FILL_COMMAND_GEN_DEFINES_SVH

// Check a property on every rising clock edge outside reset
`define LCDRF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define LCDRF_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> rtl/core/lcdrf_pkg.sv
// Shared types and constants of the rectangle fill command generator
package lcdrf_pkg;

  // Display controller commands
  localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
  localparam logic [7:0] CMD_ROW_SET      = 8'h2B;
  localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;

  // Result item kinds
  localparam logic [1:0] KIND_COMMAND = 2'd0;
  localparam logic [1:0] KIND_PARAM   = 2'd1;
  localparam logic [1:0] KIND_BURST   = 2'd2;

  // Positions within the twelve-item sequence
  localparam logic [3:0] STEP_COL_CMD  = 4'd0;
  localparam logic [3:0] STEP_XS_HI    = 4'd1;
  localparam logic [3:0] STEP_XS_LO    = 4'd2;
  localparam logic [3:0] STEP_XE_HI    = 4'd3;
  localparam logic [3:0] STEP_XE_LO    = 4'd4;
  localparam logic [3:0] STEP_ROW_CMD  = 4'd5;
  localparam logic [3:0] STEP_YS_HI    = 4'd6;
  localparam logic [3:0] STEP_YS_LO    = 4'd7;
  localparam logic [3:0] STEP_YE_HI    = 4'd8;
  localparam logic [3:0] STEP_YE_LO    = 4'd9;
  localparam logic [3:0] STEP_MEM_CMD  = 4'd10;
  localparam logic [3:0] STEP_BURST    = 4'd11;

  // Configuration registers, selected by address bit 2
  localparam logic REG_PANEL_WIDTH  = 1'b0;
  localparam logic REG_PANEL_HEIGHT = 1'b1;
  localparam logic [8:0] PANEL_WIDTH_RESET  = 9'd240;
  localparam logic [8:0] PANEL_HEIGHT_RESET = 9'd320;

  // Saturated pixel count
  localparam logic [16:0] PIXELS_MAX = 17'h1FFFF;

  // Entries in the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // One classified request, ready for sequencing
  typedef struct packed {
    logic [8:0]  x;
    logic [8:0]  y;
    logic [15:0] x_end;
    logic [15:0] y_end;
    logic [15:0] color;
    logic [16:0] pixels;
  } desc_t;

endpackage

>>> rtl/core/lcdrf_front.sv
// Front end: accepts fill requests, clips them and computes the pixel count
module lcdrf_front import lcdrf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [8:0]  panel_width_i,
  input  logic [8:0]  panel_height_i,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  logic [8:0]  origin_x_i,
  input  logic [8:0]  origin_y_i,
  input  logic [8:0]  extent_w_i,
  input  logic [8:0]  extent_h_i,
  input  logic [15:0] fill_color_i,
  output logic        desc_valid_o,
  input  logic        desc_ready_i,
  output desc_t       desc_o
);

  logic [11:0]        x_sum, y_sum;
  logic signed [10:0] w_clip, h_clip;
  logic signed [10:0] x_end_s, y_end_s;
  logic               w_pos, h_pos;

  logic        s1_valid_q, s1_valid_d;
  logic [8:0]  s1_x_q, s1_y_q, s1_w_q, s1_h_q;
  logic [15:0] s1_x_end_q, s1_y_end_q, s1_color_q;
  logic        s1_pos_q;

  logic        s2_valid_q, s2_valid_d;
  logic [8:0]  s2_x_q, s2_y_q;
  logic [15:0] s2_x_end_q, s2_y_end_q, s2_color_q;
  logic [17:0] s2_prod_q;

  logic s1_ready, s2_ready, s1_load, s2_load;

  // Clip each axis to the panel: extent becomes size minus origin on overflow
  always_comb begin
    x_sum = {3'b000, origin_x_i} + {3'b000, extent_w_i};
    y_sum = {3'b000, origin_y_i} + {3'b000, extent_h_i};
    if (x_sum > {3'b000, panel_width_i}) begin
      w_clip = $signed({2'b00, panel_width_i}) - $signed({2'b00, origin_x_i});
    end else begin
      w_clip = $signed({2'b00, extent_w_i});
    end
    if (y_sum > {3'b000, panel_height_i}) begin
      h_clip = $signed({2'b00, panel_height_i}) - $signed({2'b00, origin_y_i});
    end else begin
      h_clip = $signed({2'b00, extent_h_i});
    end
    x_end_s = $signed({2'b00, origin_x_i}) + w_clip - 11'sd1;
    y_end_s = $signed({2'b00, origin_y_i}) + h_clip - 11'sd1;
    w_pos   = !w_clip[10] && (w_clip != 11'sd0);
    h_pos   = !h_clip[10] && (h_clip != 11'sd0);
  end

  // Advance each stage when the one after it has room
  assign s2_ready    = !s2_valid_q || desc_ready_i;
  assign s1_ready    = !s1_valid_q || s2_ready;
  assign req_ready_o = s1_ready;
  assign s1_load     = req_valid_i && s1_ready;
  assign s2_load     = s1_valid_q && s2_ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_ready) begin
      s1_valid_d = req_valid_i;
    end
    s2_valid_d = s2_valid_q;
    if (s2_ready) begin
      s2_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  // Capture the clipped window
  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_x_q     <= origin_x_i;
      s1_y_q     <= origin_y_i;
      s1_x_end_q <= {{5{x_end_s[10]}}, x_end_s};
      s1_y_end_q <= {{5{y_end_s[10]}}, y_end_s};
      s1_w_q     <= w_clip[8:0];
      s1_h_q     <= h_clip[8:0];
      s1_pos_q   <= w_pos && h_pos;
      s1_color_q <= fill_color_i;
    end
  end

  // Multiply the clipped extents; drop the count when either is not positive
  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      s2_x_q     <= s1_x_q;
      s2_y_q     <= s1_y_q;
      s2_x_end_q <= s1_x_end_q;
      s2_y_end_q <= s1_y_end_q;
      s2_color_q <= s1_color_q;
      s2_prod_q  <= s1_pos_q ? (18'(s1_w_q) * 18'(s1_h_q)) : 18'd0;
    end
  end

  // Saturate the count and hand the descriptor on
  assign desc_valid_o  = s2_valid_q;
  assign desc_o.x      = s2_x_q;
  assign desc_o.y      = s2_y_q;
  assign desc_o.x_end  = s2_x_end_q;
  assign desc_o.y_end  = s2_y_end_q;
  assign desc_o.color  = s2_color_q;
  assign desc_o.pixels = s2_prod_q[17] ? PIXELS_MAX : s2_prod_q[16:0];

endmodule

>>> rtl/core/lcdrf_queue.sv
// Short descriptor queue between the front end and the sequencer
`include "lcd_rect_fill_command_gen_defines.svh"

module lcdrf_queue import lcdrf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_valid_i,
  output logic  wr_ready_o,
  input  desc_t wr_desc_i,
  output logic  rd_valid_o,
  input  logic  rd_ready_i,
  output desc_t rd_desc_o
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] CountFull = CntW'(QUEUE_DEPTH);
  localparam logic [PtrW-1:0] PtrLast   = PtrW'(QUEUE_DEPTH - 1);

  desc_t           mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            wr_en, rd_en;

  assign wr_ready_o = (count_q != CountFull);
  assign rd_valid_o = (count_q != '0);
  assign wr_en      = wr_valid_i && wr_ready_o;
  assign rd_en      = rd_ready_i && rd_valid_o;
  assign rd_desc_o  = mem_q[rd_ptr_q];

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_d = count_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the incoming descriptor
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wr_desc_i;
    end
  end

  `LCDRF_ASSERT_NEVER(a_count_bound, count_q > CountFull, "queue count beyond depth")
  `LCDRF_ASSERT(a_write_grows, wr_en && !rd_en |=> count_q == $past(count_q) + 1'b1, "write lost")
  `LCDRF_ASSERT(a_read_shrinks, rd_en && !wr_en |=> count_q == $past(count_q) - 1'b1, "read lost")

endmodule

>>> rtl/core/lcdrf_back.sv
// Sequencer: plays out the twelve controller items of one descriptor
`include "lcd_rect_fill_command_gen_defines.svh"

module lcdrf_back import lcdrf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        desc_valid_i,
  output logic        desc_ready_o,
  input  desc_t       desc_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [1:0]  item_kind_o,
  output logic [7:0]  link_byte_o,
  output logic [15:0] burst_color_o,
  output logic [16:0] burst_pixels_o,
  output logic        last_item_o
);

  logic       busy_q, busy_d;
  logic [3:0] step_q, step_d;
  desc_t      desc_q;
  logic       pop_fire, done, load;

  // Take the next descriptor as the last item of the current one leaves
  assign pop_fire     = pop_i && busy_q;
  assign done         = pop_fire && (step_q == STEP_BURST);
  assign desc_ready_o = !busy_q || done;
  assign load         = desc_valid_i && desc_ready_o;
  assign empty_o      = !busy_q;

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    if (load) begin
      busy_d = 1'b1;
      step_d = STEP_COL_CMD;
    end else if (done) begin
      busy_d = 1'b0;
    end else if (pop_fire) begin
      step_d = step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= STEP_COL_CMD;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      desc_q <= desc_i;
    end
  end

  // Select the item for the current step
  always_comb begin
    item_kind_o    = KIND_PARAM;
    link_byte_o    = 8'h00;
    burst_color_o  = 16'h0000;
    burst_pixels_o = 17'h00000;
    last_item_o    = 1'b0;
    case (step_q)
      STEP_COL_CMD: begin
        item_kind_o = KIND_COMMAND;
        link_byte_o = CMD_COLUMN_SET;
      end
      STEP_XS_HI: link_byte_o = {7'b0000000, desc_q.x[8]};
      STEP_XS_LO: link_byte_o = desc_q.x[7:0];
      STEP_XE_HI: link_byte_o = desc_q.x_end[15:8];
      STEP_XE_LO: link_byte_o = desc_q.x_end[7:0];
      STEP_ROW_CMD: begin
        item_kind_o = KIND_COMMAND;
        link_byte_o = CMD_ROW_SET;
      end
      STEP_YS_HI: link_byte_o = {7'b0000000, desc_q.y[8]};
      STEP_YS_LO: link_byte_o = desc_q.y[7:0];
      STEP_YE_HI: link_byte_o = desc_q.y_end[15:8];
      STEP_YE_LO: link_byte_o = desc_q.y_end[7:0];
      STEP_MEM_CMD: begin
        item_kind_o = KIND_COMMAND;
        link_byte_o = CMD_MEMORY_WRITE;
      end
      STEP_BURST: begin
        item_kind_o    = KIND_BURST;
        burst_color_o  = desc_q.color;
        burst_pixels_o = desc_q.pixels;
        last_item_o    = 1'b1;
      end
      default: begin
        item_kind_o = KIND_PARAM;
      end
    endcase
  end

  `LCDRF_ASSERT_NEVER(a_step_range, busy_q && step_q > STEP_BURST, "step beyond burst")
  `LCDRF_ASSERT(a_hold_step, busy_q && !pop_i |=> busy_q && $stable(step_q), "stalled item moved")
  `LCDRF_ASSERT(a_drain, done && !desc_valid_i |=> empty_o, "sequencer busy after last item")

endmodule

>>> rtl/core/lcd_rect_fill_command_gen.sv
// Top level of the rectangle fill command generator with its register port
// A request passes the two front-end stages, the queue and the sequencer register before its first item shows.
// The sequencer gives one item per cycle while pop is held, and takes the next descriptor as the last item leaves.
// The front end takes one request per cycle until its two stages and the
// two-entry queue are full.
// Reset: panel size returns to 240 by 320, pipeline and queue empty.
module lcd_rect_fill_command_gen import lcdrf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic [8:0]  origin_x_i,
  input  logic [8:0]  origin_y_i,
  input  logic [8:0]  extent_w_i,
  input  logic [8:0]  extent_h_i,
  input  logic [15:0] fill_color_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  item_kind_o,
  output logic [7:0]  link_byte_o,
  output logic [15:0] burst_color_o,
  output logic [16:0] burst_pixels_o,
  output logic        last_item_o
);

  logic [8:0] panel_width_q, panel_height_q;
  logic       cfg_write, req_ready;
  logic       fq_valid, fq_ready, qb_valid, qb_ready;
  desc_t      fq_desc, qb_desc;

  // Write panel size registers on the access phase
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      panel_width_q  <= PANEL_WIDTH_RESET;
      panel_height_q <= PANEL_HEIGHT_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_PANEL_WIDTH) begin
        panel_width_q <= pwdata[8:0];
      end else begin
        panel_height_q <= pwdata[8:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_PANEL_HEIGHT) ? {23'd0, panel_height_q}
                                                 : {23'd0, panel_width_q};

  assign full = !req_ready;

  lcdrf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .panel_width_i  (panel_width_q),
    .panel_height_i (panel_height_q),
    .req_valid_i    (push),
    .req_ready_o    (req_ready),
    .origin_x_i     (origin_x_i),
    .origin_y_i     (origin_y_i),
    .extent_w_i     (extent_w_i),
    .extent_h_i     (extent_h_i),
    .fill_color_i   (fill_color_i),
    .desc_valid_o   (fq_valid),
    .desc_ready_i   (fq_ready),
    .desc_o         (fq_desc)
  );

  lcdrf_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fq_valid),
    .wr_ready_o (fq_ready),
    .wr_desc_i  (fq_desc),
    .rd_valid_o (qb_valid),
    .rd_ready_i (qb_ready),
    .rd_desc_o  (qb_desc)
  );

  lcdrf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .desc_valid_i   (qb_valid),
    .desc_ready_o   (qb_ready),
    .desc_i         (qb_desc),
    .empty_o        (empty),
    .pop_i          (pop),
    .item_kind_o    (item_kind_o),
    .link_byte_o    (link_byte_o),
    .burst_color_o  (burst_color_o),
    .burst_pixels_o (burst_pixels_o),
    .last_item_o    (last_item_o)
  );

endmodule
